@@ hw/rtl/kwm_pkg.sv @@
// ============================================================================
// kwm_pkg
// Types and constants shared by the k-way sorted merge block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

    // Field widths fixed by the item format
    localparam int KEY_W     = 32;
    localparam int LANE_W    = 3;
    localparam int MAX_LANES = 8;

    // Default configuration
    localparam int LANES_DEF      = 8;
    localparam int LANE_DEPTH_DEF = 8;

    // One input transfer
    typedef struct packed {
        logic [LANE_W-1:0]       lane;
        logic signed [KEY_W-1:0] key;
        logic                    has_element;
        logic                    last;
    } item_t;

    // One result transfer
    typedef struct packed {
        logic signed [KEY_W-1:0] key_res;
        logic                    last_res;
        logic                    empty_res;
        logic                    overflow;
    } result_t;

    // Outcome of the head minimum search
    typedef struct packed {
        logic              found;
        logic [LANE_W-1:0] lane;
    } sel_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_WAIT,
        ST_PICK
    } state_t;

endpackage : kwm_pkg

`default_nettype wire

@@ hw/rtl/k_way_sorted_merge.sv @@
// ============================================================================
// k_way_sorted_merge
// Loads up to LANES ascending key sequences and merges them into one run.
// ============================================================================
// Usage:
//   Input: an item transfers on a rising edge with start high and busy low.
//   Each item carries a lane, a key, has_element and last. Elements go into
//   one shared RAM, LANE_DEPTH slots per lane; a full lane drops the element
//   and flags overflow on every result of that merge. Lanes at or above
//   LANES are ignored. Loading takes one item per cycle.
//   The item with last set starts the merge and raises busy. The merge first
//   reads the head of every lane from the RAM, then emits results by turns
//   of two steps: a pick step chooses the smallest head through a compare
//   tree and issues the RAM read of that lane's next element, and a wait
//   step lets the registered RAM read land in the head register. An empty
//   load gives one result with empty_res set, in the cycle after the last
//   item, and no busy period.
//   Output: each result is on result for one cycle with strobe high; the
//   receiver cannot stall it. last_res marks the final result.
//   Reset clears counts, cursors, the overflow flag and the sequencer; the
//   RAM holds no reset value and is read only where written in this load.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module k_way_sorted_merge #(
    parameter int LANES      = kwm_pkg::LANES_DEF,
    parameter int LANE_DEPTH = kwm_pkg::LANE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire kwm_pkg::item_t item,
    output logic               strobe,
    output kwm_pkg::result_t   result
);

    localparam int LIW   = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CW    = $clog2(LANE_DEPTH + 1);
    localparam int DEPTH = LANES * LANE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1);

    kwm_pkg::state_t state_reg, state_next;

    logic [CW-1:0]  cnt_reg  [LANES];
    logic [CW-1:0]  cnt_next [LANES];
    logic [CW-1:0]  pos_reg  [LANES];
    logic [CW-1:0]  pos_next [LANES];
    logic [TW-1:0]  total_reg, total_next;
    logic           ovf_reg, ovf_next;
    logic [LIW-1:0] fill_reg, fill_next;
    logic [LIW-1:0] rd_lane_reg, rd_lane_next;
    logic           rd_pend_reg, rd_pend_next;
    logic           strobe_reg, strobe_next;
    kwm_pkg::result_t res_reg, res_next;

    logic signed [kwm_pkg::KEY_W-1:0] head_reg [LANES];

    // RAM ports
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [kwm_pkg::KEY_W-1:0] ram_rdata;

    // Head search
    logic [kwm_pkg::MAX_LANES-1:0]    head_valid;
    logic signed [kwm_pkg::KEY_W-1:0] head_keys [kwm_pkg::MAX_LANES];
    kwm_pkg::sel_t                    sel;

    logic [LIW-1:0] in_lane;
    logic           in_range;
    logic [LIW-1:0] best;
    logic [CW-1:0]  pos_inc;

    function automatic logic [AW-1:0] addr_of(input logic [LIW-1:0] l,
                                              input logic [CW-1:0]  p);
        addr_of = AW'(l) * AW'(LANE_DEPTH) + AW'(p);
    endfunction

    assign in_lane  = item.lane[LIW-1:0];
    assign in_range = int'(item.lane) < LANES;
    assign best     = sel.lane[LIW-1:0];
    assign pos_inc  = pos_reg[best] + 1'b1;

    // Element store
    kwm_ram #(
        .WIDTH (kwm_pkg::KEY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item.key),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Lane heads into the compare tree; unused leaves stay invalid
    for (genvar g = 0; g < kwm_pkg::MAX_LANES; g++)
    begin : g_leaf
        if (g < LANES)
        begin : g_used
            assign head_valid[g] = pos_reg[g] < cnt_reg[g];
            assign head_keys[g]  = head_reg[g];
        end
        else
        begin : g_unused
            assign head_valid[g] = 1'b0;
            assign head_keys[g]  = '0;
        end
    end

    kwm_min_select u_min (
        .valid (head_valid),
        .keys  (head_keys),
        .sel   (sel)
    );

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kwm_pkg::ST_IDLE;
            total_reg   <= '0;
            ovf_reg     <= 1'b0;
            fill_reg    <= '0;
            rd_lane_reg <= '0;
            rd_pend_reg <= 1'b0;
            strobe_reg  <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                cnt_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            ovf_reg     <= ovf_next;
            fill_reg    <= fill_next;
            rd_lane_reg <= rd_lane_next;
            rd_pend_reg <= rd_pend_next;
            strobe_reg  <= strobe_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
        end
    end

    // Payload registers: result and lane heads
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (rd_pend_reg)
        begin
            head_reg[rd_lane_reg] <= ram_rdata;
        end
    end

    // Next state and RAM control
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        total_next   = total_reg;
        ovf_next     = ovf_reg;
        fill_next    = fill_reg;
        rd_lane_next = rd_lane_reg;
        rd_pend_next = 1'b0;
        strobe_next  = 1'b0;
        res_next     = res_reg;
        ram_we       = 1'b0;
        ram_waddr    = addr_of(in_lane, '0);
        ram_re       = 1'b0;
        ram_raddr    = '0;
        busy         = 1'b1;

        case (state_reg)
            kwm_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    // store or drop the element
                    if (item.has_element && in_range)
                    begin
                        if (cnt_reg[in_lane] < CW'(LANE_DEPTH))
                        begin
                            ram_we             = 1'b1;
                            ram_waddr          = addr_of(in_lane, cnt_reg[in_lane]);
                            cnt_next[in_lane]  = cnt_reg[in_lane] + 1'b1;
                            total_next         = total_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (item.last)
                    begin
                        if (total_next == '0)
                        begin
                            // empty load: single flagged result
                            strobe_next        = 1'b1;
                            res_next.key_res   = '0;
                            res_next.last_res  = 1'b1;
                            res_next.empty_res = 1'b1;
                            res_next.overflow  = ovf_next;
                            ovf_next           = 1'b0;
                        end
                        else
                        begin
                            fill_next  = '0;
                            state_next = kwm_pkg::ST_FILL;
                        end
                    end
                end
            end

            kwm_pkg::ST_FILL:
            begin
                // fetch the first element of each non-empty lane
                ram_re       = cnt_reg[fill_reg] != '0;
                ram_raddr    = addr_of(fill_reg, '0);
                rd_pend_next = ram_re;
                rd_lane_next = fill_reg;
                if (fill_reg == LIW'(LANES - 1))
                begin
                    state_next = kwm_pkg::ST_WAIT;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end

            kwm_pkg::ST_WAIT:
            begin
                // read data lands in the head register this cycle
                state_next = kwm_pkg::ST_PICK;
            end

            kwm_pkg::ST_PICK:
            begin
                strobe_next        = 1'b1;
                res_next.key_res   = head_reg[best];
                res_next.last_res  = total_reg == TW'(1);
                res_next.empty_res = 1'b0;
                res_next.overflow  = ovf_reg;
                pos_next[best]     = pos_inc;
                total_next         = total_reg - 1'b1;
                // refill the winning lane's head
                ram_re       = pos_inc < cnt_reg[best];
                ram_raddr    = addr_of(best, pos_inc);
                rd_pend_next = ram_re;
                rd_lane_next = best;
                if (total_reg == TW'(1))
                begin
                    // merge done: clear for the next load
                    for (int i = 0; i < LANES; i++)
                    begin
                        cnt_next[i] = '0;
                        pos_next[i] = '0;
                    end
                    ovf_next     = 1'b0;
                    rd_pend_next = 1'b0;
                    ram_re       = 1'b0;
                    state_next   = kwm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = kwm_pkg::ST_WAIT;
                end
            end

            default:
            begin
                state_next = kwm_pkg::ST_IDLE;
            end
        endcase
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // a final result leaves the block ready for the next load
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last_res |-> !busy)
        else $error("block busy after final result");

    // an empty result is always the only one
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.empty_res |-> result.last_res)
        else $error("empty result without last flag");

    // picking needs a valid head and elements left
    a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kwm_pkg::ST_PICK |-> sel.found && (total_reg != '0))
        else $error("pick with no valid lane head");

    // read data is only captured while heads are being loaded
    a_rd_window: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == kwm_pkg::ST_FILL || state_reg == kwm_pkg::ST_WAIT))
        else $error("head capture outside fill or wait");

endmodule : k_way_sorted_merge

`default_nettype wire

@@ hw/rtl/kwm_ram.sv @@
// ============================================================================
// kwm_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : kwm_ram

`default_nettype wire

@@ hw/rtl/kwm_min_select.sv @@
// ============================================================================
// kwm_min_select
// Three-level compare tree that finds the smallest valid lane head.
// Ties resolve to the lower lane.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module kwm_min_select (
    input  wire logic [kwm_pkg::MAX_LANES-1:0]   valid,
    input  wire logic signed [kwm_pkg::KEY_W-1:0] keys [kwm_pkg::MAX_LANES],
    output kwm_pkg::sel_t                        sel
);

    logic                              v1 [4];
    logic signed [kwm_pkg::KEY_W-1:0]  k1 [4];
    logic [kwm_pkg::LANE_W-1:0]        l1 [4];
    logic                              v2 [2];
    logic signed [kwm_pkg::KEY_W-1:0]  k2 [2];
    logic [kwm_pkg::LANE_W-1:0]        l2 [2];
    logic                              take_r;

    // right side wins only when strictly smaller, so ties keep the lower lane
    function automatic logic pick_right(
        input logic                             va,
        input logic signed [kwm_pkg::KEY_W-1:0] ka,
        input logic                             vb,
        input logic signed [kwm_pkg::KEY_W-1:0] kb
    );
        pick_right = vb && (!va || (kb < ka));
    endfunction

    always_comb
    begin
        // first level: pairs of lanes
        for (int i = 0; i < 4; i++)
        begin
            if (pick_right(valid[2*i], keys[2*i], valid[2*i+1], keys[2*i+1]))
            begin
                k1[i] = keys[2*i+1];
                l1[i] = kwm_pkg::LANE_W'(2*i+1);
            end
            else
            begin
                k1[i] = keys[2*i];
                l1[i] = kwm_pkg::LANE_W'(2*i);
            end
            v1[i] = valid[2*i] | valid[2*i+1];
        end
        // second level
        for (int i = 0; i < 2; i++)
        begin
            if (pick_right(v1[2*i], k1[2*i], v1[2*i+1], k1[2*i+1]))
            begin
                k2[i] = k1[2*i+1];
                l2[i] = l1[2*i+1];
            end
            else
            begin
                k2[i] = k1[2*i];
                l2[i] = l1[2*i];
            end
            v2[i] = v1[2*i] | v1[2*i+1];
        end
        // root
        take_r    = pick_right(v2[0], k2[0], v2[1], k2[1]);
        sel.found = v2[0] | v2[1];
        sel.lane  = take_r ? l2[1] : l2[0];
    end

endmodule : kwm_min_select

`default_nettype wire
